// ----- design/khm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_pkg
// Shared field widths, item codes and the sort key type for the heap merge.
// ----------------------------------------------------------------------------
package khm_pkg;

  localparam int MODE_W = 2;
  localparam int SEQ_W  = 24;
  localparam int POS_W  = 32;
  localparam int PAY_W  = 64;
  localparam int RSRC_W = 8;

  localparam logic [MODE_W-1:0] MODE_PRIME  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REFILL = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [POS_W-1:0] pos;
  } key_t;

endpackage

// ----- design/k_way_heap_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_heap_merge
// K-way merge of presorted record streams through a binary min-heap.
// ----------------------------------------------------------------------------
// A prime item that is not exhausted is written straight into the heap RAM. A
// start item builds the heap bottom-up and a refill item sifts the new head
// down from the root; both then read the root and present the result. Each heap
// level visited takes the steps child read, left compare, right compare (only
// with a right child) and write back on the single comparator and the one
// dual-read heap RAM; a start runs at most MAX_SOURCES/2 such sifts. Input
// stall is high whenever an item is being worked on; a result waits in the
// output register while the next item is taken.
// ----------------------------------------------------------------------------
module k_way_heap_merge #(
  parameter int MAX_SOURCES = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [khm_pkg::MODE_W-1:0]  in_mode,
  input  logic                        in_exhausted,
  input  logic [khm_pkg::SEQ_W-1:0]   in_seq_index,
  input  logic [khm_pkg::POS_W-1:0]   in_position,
  input  logic [khm_pkg::PAY_W-1:0]   in_payload,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_record_valid,
  output logic [khm_pkg::SEQ_W-1:0]   out_seq_index,
  output logic [khm_pkg::POS_W-1:0]   out_position,
  output logic [khm_pkg::PAY_W-1:0]   out_payload,
  output logic [khm_pkg::RSRC_W-1:0]  out_refill_source,
  output logic                        out_new_sequence,
  output logic                        out_done_res
);

  localparam int ADDR_W = $clog2(MAX_SOURCES);
  localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
  localparam int IDX_W  = ADDR_W + 2;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SOURCES);

  typedef struct packed {
    khm_pkg::key_t             key;
    logic [khm_pkg::PAY_W-1:0] payload;
    logic [ADDR_W-1:0]         src;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  typedef enum logic [3:0] {
    S_IDLE, S_BLD_RD, S_LOAD, S_SIFT_RD, S_SIFT_L, S_SIFT_R, S_SIFT_W, S_TOP_RD, S_EMIT
  } state_t;

  state_t            state_r;
  state_t            after_node;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  primed_r;
  logic              merging_r;
  logic              building_r;
  logic              done_pend_r;
  logic              moved_r;
  logic [CNT_W-1:0]  k_r;
  logic [ADDR_W-1:0] at_r;
  logic [ADDR_W-1:0] best_idx_r;
  logic [ADDR_W-1:0] top_src_r;
  item_t             cur_r;
  item_t             best_r;
  logic [khm_pkg::SEQ_W-1:0] last_seq_r;
  logic              last_valid_r;

  logic              out_valid_r;
  logic              out_record_valid_r;
  logic [khm_pkg::SEQ_W-1:0]  out_seq_r;
  logic [khm_pkg::POS_W-1:0]  out_pos_r;
  logic [khm_pkg::PAY_W-1:0]  out_pay_r;
  logic [khm_pkg::RSRC_W-1:0] out_rsrc_r;
  logic              out_new_seq_r;
  logic              out_done_r;

  logic              in_acc;
  logic              out_free;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  k_dec;
  logic [IDX_W-1:0]  lft;
  logic [IDX_W-1:0]  rgt;
  logic [IDX_W-1:0]  cnt_ext;
  logic              has_lft;
  logic              has_rgt;
  logic              prime_ok;
  logic [31:0]       src_ext;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  item_t             ram_wdata;
  logic              ram_re_a;
  logic [ADDR_W-1:0] ram_raddr_a;
  logic [ITEM_W-1:0] ram_rdata_a;
  logic              ram_re_b;
  logic [ADDR_W-1:0] ram_raddr_b;
  logic [ITEM_W-1:0] ram_rdata_b;
  item_t             rd_a;
  item_t             rd_b;

  khm_pkg::key_t     cmp_a;
  khm_pkg::key_t     cmp_b;
  logic              cmp_less;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign rd_a    = item_t'(ram_rdata_a);
  assign rd_b    = item_t'(ram_rdata_b);
  assign cnt_dec = count_r - CNT_W'(1);
  assign k_dec   = k_r - CNT_W'(1);
  assign lft     = IDX_W'({at_r, 1'b1});
  assign rgt     = lft + IDX_W'(1);
  assign cnt_ext = IDX_W'(count_r);
  assign has_lft = (lft < cnt_ext);
  assign has_rgt = (rgt < cnt_ext);
  assign src_ext = 32'(rd_a.src);
  assign prime_ok = !merging_r && (primed_r < MAX_CNT);

  // Where to go once the current node has settled.
  always_comb begin
    if (building_r && (k_r > CNT_W'(1))) begin
      after_node = S_BLD_RD;
    end else begin
      after_node = S_TOP_RD;
    end
  end

  // RAM port and comparator steering.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = at_r;
    ram_wdata   = cur_r;
    ram_re_a    = 1'b0;
    ram_raddr_a = '0;
    ram_re_b    = 1'b0;
    ram_raddr_b = '0;
    cmp_a       = rd_a.key;
    cmp_b       = cur_r.key;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == khm_pkg::MODE_PRIME) && prime_ok && !in_exhausted &&
            (count_r < MAX_CNT)) begin
          ram_we    = 1'b1;
          ram_waddr = count_r[ADDR_W-1:0];
          ram_wdata = '{key: '{seq: in_seq_index, pos: in_position},
                        payload: in_payload, src: primed_r[ADDR_W-1:0]};
        end
        if (in_acc && (in_mode == khm_pkg::MODE_REFILL) && merging_r && in_exhausted &&
            (count_r > CNT_W'(1))) begin
          // fetch the last entry to move into the root
          ram_re_a    = 1'b1;
          ram_raddr_a = cnt_dec[ADDR_W-1:0];
        end
      end
      S_BLD_RD: begin
        ram_re_a    = 1'b1;
        ram_raddr_a = k_dec[ADDR_W-1:0];
      end
      S_SIFT_RD: begin
        if (!has_lft) begin
          ram_we = 1'b1;
        end else begin
          ram_re_a    = 1'b1;
          ram_raddr_a = lft[ADDR_W-1:0];
          ram_re_b    = has_rgt;
          ram_raddr_b = rgt[ADDR_W-1:0];
        end
      end
      S_SIFT_R: begin
        cmp_a = rd_b.key;
        cmp_b = best_r.key;
      end
      S_SIFT_W: begin
        ram_we    = 1'b1;
        ram_wdata = moved_r ? best_r : cur_r;
      end
      S_TOP_RD: begin
        ram_re_a    = 1'b1;
        ram_raddr_a = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      primed_r     <= '0;
      merging_r    <= 1'b0;
      building_r   <= 1'b0;
      done_pend_r  <= 1'b0;
      last_seq_r   <= '0;
      last_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_mode)
              khm_pkg::MODE_PRIME: begin
                if (prime_ok) begin
                  if (!in_exhausted && (count_r < MAX_CNT)) begin
                    count_r <= count_r + CNT_W'(1);
                  end
                  primed_r <= primed_r + CNT_W'(1);
                end
              end
              khm_pkg::MODE_START: begin
                if (!merging_r) begin
                  merging_r    <= 1'b1;
                  last_valid_r <= 1'b0;
                  building_r   <= 1'b1;
                  done_pend_r  <= (count_r == '0);
                  k_r          <= count_r >> 1;
                  if (count_r == '0) begin
                    state_r <= S_EMIT;
                  end else if (count_r == CNT_W'(1)) begin
                    state_r <= S_TOP_RD;
                  end else begin
                    state_r <= S_BLD_RD;
                  end
                end
              end
              khm_pkg::MODE_REFILL: begin
                if (merging_r && (count_r != '0)) begin
                  building_r <= 1'b0;
                  at_r       <= '0;
                  if (!in_exhausted) begin
                    done_pend_r <= 1'b0;
                    cur_r <= '{key: '{seq: in_seq_index, pos: in_position},
                               payload: in_payload, src: top_src_r};
                    state_r <= S_SIFT_RD;
                  end else begin
                    count_r     <= cnt_dec;
                    done_pend_r <= (cnt_dec == '0);
                    state_r     <= (cnt_dec == '0) ? S_EMIT : S_LOAD;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_BLD_RD: begin
          at_r    <= k_dec[ADDR_W-1:0];
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          cur_r   <= rd_a;
          state_r <= S_SIFT_RD;
        end
        S_SIFT_RD: begin
          if (!has_lft) begin
            if (after_node == S_BLD_RD) begin
              k_r <= k_dec;
            end
            state_r <= after_node;
          end else begin
            state_r <= S_SIFT_L;
          end
        end
        S_SIFT_L: begin
          if (cmp_less) begin
            best_r     <= rd_a;
            best_idx_r <= lft[ADDR_W-1:0];
            moved_r    <= 1'b1;
          end else begin
            best_r  <= cur_r;
            moved_r <= 1'b0;
          end
          state_r <= has_rgt ? S_SIFT_R : S_SIFT_W;
        end
        S_SIFT_R: begin
          if (cmp_less) begin
            best_r     <= rd_b;
            best_idx_r <= rgt[ADDR_W-1:0];
            moved_r    <= 1'b1;
          end
          state_r <= S_SIFT_W;
        end
        S_SIFT_W: begin
          if (moved_r) begin
            // child moved up: follow the hole down
            at_r    <= best_idx_r;
            state_r <= S_SIFT_RD;
          end else begin
            if (after_node == S_BLD_RD) begin
              k_r <= k_dec;
            end
            state_r <= after_node;
          end
        end
        S_TOP_RD: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (done_pend_r) begin
              out_record_valid_r <= 1'b0;
              out_seq_r          <= '0;
              out_pos_r          <= '0;
              out_pay_r          <= '0;
              out_rsrc_r         <= '0;
              out_new_seq_r      <= 1'b0;
              out_done_r         <= 1'b1;
              count_r            <= '0;
              primed_r           <= '0;
              merging_r          <= 1'b0;
              last_valid_r       <= 1'b0;
              done_pend_r        <= 1'b0;
            end else begin
              out_record_valid_r <= 1'b1;
              out_seq_r          <= rd_a.key.seq;
              out_pos_r          <= rd_a.key.pos;
              out_pay_r          <= rd_a.payload;
              out_rsrc_r         <= src_ext[khm_pkg::RSRC_W-1:0];
              out_new_seq_r      <= !last_valid_r || (last_seq_r != rd_a.key.seq);
              out_done_r         <= 1'b0;
              last_seq_r         <= rd_a.key.seq;
              last_valid_r       <= 1'b1;
              top_src_r          <= rd_a.src;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  khm_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (MAX_SOURCES)
  ) u_heap (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re_a    (ram_re_a),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .re_b    (ram_re_b),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  khm_cmp u_cmp (
    .a    (cmp_a),
    .b    (cmp_b),
    .less (cmp_less)
  );

  assign out_valid         = out_valid_r;
  assign out_record_valid  = out_record_valid_r;
  assign out_seq_index     = out_seq_r;
  assign out_position      = out_pos_r;
  assign out_payload       = out_pay_r;
  assign out_refill_source = out_rsrc_r;
  assign out_new_sequence  = out_new_seq_r;
  assign out_done_res      = out_done_r;

endmodule

// ----- design/khm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module khm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- design/khm_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khm_cmp
// Shared key comparator: sequence index first, then position, strict less.
// ----------------------------------------------------------------------------
module khm_cmp (
  input  khm_pkg::key_t a,
  input  khm_pkg::key_t b,
  output logic          less
);

  always_comb begin
    if (a.seq != b.seq) begin
      less = (a.seq < b.seq);
    end else begin
      less = (a.pos < b.pos);
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the k-way heap merge: primed sources, heap build and refills.
// ----------------------------------------------------------------------------
// The sender drives sorted per-source record streams and a little noise. Every
// accepted item runs through a heap model kept here, and the merged records it
// predicts are queued. Each result transfer is compared with the oldest entry
// in that queue. Sender gaps and receiver stalls vary from test to test.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_SRC = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int END_WAIT = 300;
  localparam logic [khm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [khm_pkg::SEQ_W-1:0] seq;
    logic [khm_pkg::POS_W-1:0] pos;
    logic [khm_pkg::PAY_W-1:0] pay;
    logic [15:0]               src;
  } heap_rec_t;

  typedef struct packed {
    logic                       rec_valid;
    logic [khm_pkg::SEQ_W-1:0]  seq;
    logic [khm_pkg::POS_W-1:0]  pos;
    logic [khm_pkg::PAY_W-1:0]  pay;
    logic [khm_pkg::RSRC_W-1:0] src;
    logic                       new_seq;
    logic                       done;
  } merge_out_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [khm_pkg::MODE_W-1:0] in_mode = khm_pkg::MODE_PRIME;
  logic                       in_exhausted = 1'b0;
  logic [khm_pkg::SEQ_W-1:0]  in_seq_index = '0;
  logic [khm_pkg::POS_W-1:0]  in_position = '0;
  logic [khm_pkg::PAY_W-1:0]  in_payload = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_record_valid;
  logic [khm_pkg::SEQ_W-1:0]  out_seq_index;
  logic [khm_pkg::POS_W-1:0]  out_position;
  logic [khm_pkg::PAY_W-1:0]  out_payload;
  logic [khm_pkg::RSRC_W-1:0] out_refill_source;
  logic                       out_new_sequence;
  logic                       out_done_res;

  // heap model
  heap_rec_t                 heap_m [MAX_SRC];
  int unsigned               heap_cnt = 0;
  int unsigned               primed_cnt = 0;
  bit                        merge_on = 1'b0;
  logic [khm_pkg::SEQ_W-1:0] last_seq = '0;
  bit                        last_seq_ok = 1'b0;

  merge_out_t pending_merge_out[$];
  int         item_cnt = 0;
  int         fail_cnt = 0;
  int         cycle_cnt = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         rx_hold_left = 0;

  k_way_heap_merge #(
    .MAX_SOURCES(MAX_SRC)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_exhausted      (in_exhausted),
    .in_seq_index      (in_seq_index),
    .in_position       (in_position),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_record_valid  (out_record_valid),
    .out_seq_index     (out_seq_index),
    .out_position      (out_position),
    .out_payload       (out_payload),
    .out_refill_source (out_refill_source),
    .out_new_sequence  (out_new_sequence),
    .out_done_res      (out_done_res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("k_way_heap_merge regression: fail");
      $finish;
    end
  end

  // receiver: a long hold-off takes priority over random stalls
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  function automatic bit key_lt(heap_rec_t a, heap_rec_t b);
    return {a.seq, a.pos} < {b.seq, b.pos};
  endfunction

  function automatic void heap_sift(int unsigned at);
    int unsigned lft;
    int unsigned rgt;
    int unsigned best;
    heap_rec_t   t;
    while (1) begin
      lft = 2 * at + 1;
      rgt = lft + 1;
      best = at;
      if (lft < heap_cnt && key_lt(heap_m[lft], heap_m[best])) best = lft;
      if (rgt < heap_cnt && key_lt(heap_m[rgt], heap_m[best])) best = rgt;
      if (best == at) break;
      t = heap_m[at];
      heap_m[at] = heap_m[best];
      heap_m[best] = t;
      at = best;
    end
  endfunction

  function automatic void emit_top();
    merge_out_t r;
    r = '0;
    if (heap_cnt == 0) begin
      r.done = 1'b1;
      primed_cnt = 0;
      merge_on = 1'b0;
      last_seq_ok = 1'b0;
    end else begin
      r.rec_valid = 1'b1;
      r.seq = heap_m[0].seq;
      r.pos = heap_m[0].pos;
      r.pay = heap_m[0].pay;
      r.src = heap_m[0].src[khm_pkg::RSRC_W-1:0];
      r.new_seq = !last_seq_ok || (last_seq != heap_m[0].seq);
      last_seq = heap_m[0].seq;
      last_seq_ok = 1'b1;
    end
    pending_merge_out.push_back(r);
  endfunction

  // returns 1 when the item changes state, 0 when the block ignores it
  function automatic bit merge_predict(logic [khm_pkg::MODE_W-1:0] mode, bit exh,
                                       logic [khm_pkg::SEQ_W-1:0] seq,
                                       logic [khm_pkg::POS_W-1:0] pos,
                                       logic [khm_pkg::PAY_W-1:0] pay);
    int unsigned k;
    case (mode)
      khm_pkg::MODE_PRIME: begin
        if (merge_on || primed_cnt >= MAX_SRC) return 1'b0;
        if (!exh && heap_cnt < MAX_SRC) begin
          heap_m[heap_cnt] = '{seq: seq, pos: pos, pay: pay, src: primed_cnt[15:0]};
          heap_cnt++;
        end
        primed_cnt++;
        return 1'b1;
      end
      khm_pkg::MODE_START: begin
        if (merge_on) return 1'b0;
        merge_on = 1'b1;
        last_seq_ok = 1'b0;
        for (k = heap_cnt / 2; k > 0; k--) heap_sift(k - 1);
        emit_top();
        return 1'b1;
      end
      khm_pkg::MODE_REFILL: begin
        if (!merge_on || heap_cnt == 0) return 1'b0;
        if (!exh) begin
          heap_m[0].seq = seq;
          heap_m[0].pos = pos;
          heap_m[0].pay = pay;
          heap_sift(0);
        end else begin
          heap_cnt--;
          heap_m[0] = heap_m[heap_cnt];
          if (heap_cnt > 0) heap_sift(0);
        end
        emit_top();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v,
                                      logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    merge_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_merge_out.size() == 0) begin
        $error("unexpected result transfer: seq %0h pos %0h done %0b",
               out_seq_index, out_position, out_done_res);
        fail_cnt++;
      end else begin
        e = pending_merge_out.pop_front();
        check_field("record_valid", 64'(e.rec_valid), 64'(out_record_valid));
        check_field("seq_index", 64'(e.seq), 64'(out_seq_index));
        check_field("position", 64'(e.pos), 64'(out_position));
        check_field("payload", e.pay, out_payload);
        check_field("refill_source", 64'(e.src), 64'(out_refill_source));
        check_field("new_sequence", 64'(e.new_seq), 64'(out_new_sequence));
        check_field("done_res", 64'(e.done), 64'(out_done_res));
      end
    end
  end

  // entered and left at a falling edge at which in_valid is not yet driven
  task automatic send_item(logic [khm_pkg::MODE_W-1:0] mode, bit exh,
                           logic [khm_pkg::SEQ_W-1:0] seq,
                           logic [khm_pkg::POS_W-1:0] pos,
                           logic [khm_pkg::PAY_W-1:0] pay);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_exhausted <= exh;
    in_seq_index <= seq;
    in_position <= pos;
    in_payload <= pay;
    do @(posedge clk); while (in_stall);
    if (merge_predict(mode, exh, seq, pos, pay)) item_cnt++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_merge_out.size() != 0) @(negedge clk);
  endtask

  function automatic logic [khm_pkg::PAY_W-1:0] rand_pay();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [khm_pkg::SEQ_W-1:0] rand_seq();
    return khm_pkg::SEQ_W'($urandom());
  endfunction

  function automatic logic [khm_pkg::POS_W-1:0] rand_pos();
    return $urandom();
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // advance a sorted stream key, saturating at the top of both fields
  function automatic void step_key(inout logic [khm_pkg::SEQ_W-1:0] seq,
                                   inout logic [khm_pkg::POS_W-1:0] pos);
    if ($urandom_range(1) == 0 || seq == {khm_pkg::SEQ_W{1'b1}}) begin
      if (pos <= 32'hFFFF_FFFC) pos = pos + $urandom_range(0, 3);
    end else begin
      seq = seq + khm_pkg::SEQ_W'(1);
      pos = $urandom_range(1) ? $urandom_range(0, 7) : $urandom();
    end
  endfunction

  task automatic run_session(int n_src, int max_len, int noise_pct, int pause_pct);
    logic [khm_pkg::SEQ_W-1:0] s_seq[MAX_SRC];
    logic [khm_pkg::POS_W-1:0] s_pos[MAX_SRC];
    int                        s_left[MAX_SRC];
    logic [khm_pkg::SEQ_W-1:0] seq;
    logic [khm_pkg::POS_W-1:0] pos;
    int                        base_kind;
    int                        src;
    int                        i;
    base_kind = $urandom_range(0, 3);
    for (i = 0; i < n_src; i++) begin
      case (base_kind)
        0: begin
          seq = khm_pkg::SEQ_W'($urandom_range(0, 3));
          pos = $urandom_range(0, 3);
        end
        1: begin
          seq = khm_pkg::SEQ_W'({khm_pkg::SEQ_W{1'b1}} - $urandom_range(0, 2));
          pos = 32'hFFFF_FFFF - $urandom_range(0, 6);
        end
        default: begin
          seq = rand_seq();
          pos = rand_pos();
        end
      endcase
      if (i < MAX_SRC) begin
        s_seq[i] = seq;
        s_pos[i] = pos;
        s_left[i] = $urandom_range(0, max_len);
      end
      send_item(khm_pkg::MODE_PRIME, $urandom_range(99) < 10, seq, pos, rand_pay());
      if ($urandom_range(99) < noise_pct)
        send_item(khm_pkg::MODE_REFILL, rand_bit(), rand_seq(), rand_pos(), rand_pay());
    end
    send_item(khm_pkg::MODE_START, rand_bit(), rand_seq(), rand_pos(), rand_pay());
    while (merge_on) begin
      src = int'(heap_m[0].src);
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(0, 4))
          0: send_item(khm_pkg::MODE_PRIME, rand_bit(), rand_seq(), rand_pos(), rand_pay());
          1: send_item(khm_pkg::MODE_START, rand_bit(), rand_seq(), rand_pos(), rand_pay());
          2: send_item(MODE_UNUSED, rand_bit(), rand_seq(), rand_pos(), rand_pay());
          3: send_item(khm_pkg::MODE_REFILL, 1'b1, rand_seq(), rand_pos(), rand_pay());
          default: send_item(khm_pkg::MODE_REFILL, 1'b0, rand_seq(), rand_pos(), rand_pay());
        endcase
      end else if (s_left[src] == 0) begin
        send_item(khm_pkg::MODE_REFILL, 1'b1, rand_seq(), rand_pos(), rand_pay());
      end else begin
        step_key(s_seq[src], s_pos[src]);
        s_left[src]--;
        send_item(khm_pkg::MODE_REFILL, 1'b0, s_seq[src], s_pos[src], rand_pay());
      end
      if ($urandom_range(99) < pause_pct) wait_drain();
    end
    if ($urandom_range(99) < noise_pct)
      send_item(khm_pkg::MODE_REFILL, 1'b0, rand_seq(), rand_pos(), rand_pay());
  endtask

  task automatic set_idling(int tx, int rx);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
  endtask

  task automatic test_idle_items();
    set_idling(0, 0);
    send_item(khm_pkg::MODE_REFILL, 1'b0, 24'h12, 32'h34, 64'h56);
    send_item(MODE_UNUSED, 1'b0, 24'h1, 32'h1, 64'h1);
    // empty merge finishes at once
    send_item(khm_pkg::MODE_START, 1'b0, '0, '0, '0);
    send_item(khm_pkg::MODE_PRIME, 1'b1, 24'hFFFFFF, 32'hFFFF_FFFF, '1);
    send_item(khm_pkg::MODE_PRIME, 1'b1, '0, '0, '0);
    send_item(khm_pkg::MODE_START, 1'b0, '0, '0, '0);
    send_item(khm_pkg::MODE_REFILL, 1'b1, '0, '0, '0);
    wait_drain();
  endtask

  task automatic test_extremes();
    set_idling(0, 0);
    send_item(khm_pkg::MODE_PRIME, 1'b0, 24'hFFFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(khm_pkg::MODE_PRIME, 1'b0, 24'h0, 32'h0, 64'h0);
    send_item(khm_pkg::MODE_PRIME, 1'b1, 24'h0, 32'h0, 64'h0);
    send_item(khm_pkg::MODE_PRIME, 1'b0, 24'h0, 32'hFFFF_FFFF, 64'hA5A5_A5A5_A5A5_A5A5);
    send_item(khm_pkg::MODE_PRIME, 1'b0, 24'hFFFFFF, 32'h0, 64'h5A5A_5A5A_5A5A_5A5A);
    // equal key with source one: tie order follows the heap build
    send_item(khm_pkg::MODE_PRIME, 1'b0, 24'h0, 32'h0, 64'h0123_4567_89AB_CDEF);
    send_item(khm_pkg::MODE_START, 1'b0, '0, '0, '0);
    // ignored while merging
    send_item(khm_pkg::MODE_PRIME, 1'b0, 24'h0, 32'h0, 64'h1);
    send_item(khm_pkg::MODE_START, 1'b0, '0, '0, '0);
    send_item(MODE_UNUSED, 1'b0, '0, '0, '0);
    // same sequence index again: no new sequence flag
    send_item(khm_pkg::MODE_REFILL, 1'b0, 24'h0, 32'h5, 64'hDEAD_BEEF_0000_0001);
    while (merge_on)
      send_item(khm_pkg::MODE_REFILL, 1'b1, rand_seq(), rand_pos(), rand_pay());
    wait_drain();
  endtask

  task automatic test_full_width();
    set_idling(6, 6);
    // three primes past the last source number are dropped
    run_session(MAX_SRC + 3, 1, 0, 0);
    wait_drain();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    rx_hold_left = 800;
    run_session(8, 10, 0, 0);
    wait_drain();
  endtask

  task automatic test_drain_pause();
    set_idling(0, 0);
    run_session(5, 6, 0, 30);
    wait_drain();
  endtask

  task automatic test_random_traffic(int tx, int rx, int budget);
    int target;
    target = item_cnt + budget;
    set_idling(tx, rx);
    while (item_cnt < target) begin
      if ($urandom_range(9) == 0) run_session($urandom_range(13, 40), $urandom_range(0, 6), 5, 1);
      else run_session($urandom_range(1, 12), $urandom_range(0, 6), 5, 1);
    end
    wait_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_items();
    test_extremes();
    test_backpressure();
    test_drain_pause();
    test_full_width();
    test_random_traffic(0, 0, 300);
    test_random_traffic(80, 0, 300);
    test_random_traffic(0, 80, 300);
    test_random_traffic(6, 6, 300);
    wait_drain();
    repeat (END_WAIT) @(negedge clk);
    if (fail_cnt == 0 && pending_merge_out.size() == 0) begin
      $display("k_way_heap_merge regression: pass");
    end else begin
      $display("k_way_heap_merge regression: fail");
    end
    $finish;
  end

endmodule
